/* design/fpsl_pkg.sv */
`default_nettype none
package fpsl_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BitIdxW = $clog2(BITS_PER_BYTE);

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE          = 3'd0,
    ST_WAITING       = 3'd1,
    ST_READY         = 3'd2,
    ST_TIMEOUT       = 3'd3,
    ST_NSTATUS_FAIL  = 3'd4,
    ST_CONFDONE_FAIL = 3'd5,
    ST_LOADED        = 3'd6,
    ST_IGNORED       = 3'd7
  } status_e;

  typedef enum logic [0:0] {
    REG_POLL_LIMIT   = 1'b0,
    REG_EXTRA_CLOCKS = 1'b1
  } reg_idx_e;

  localparam logic [7:0] PollLimitReset   = 8'd255;
  localparam logic [2:0] ExtraClocksReset = 3'd3;
  localparam logic [7:0] PollCountMax     = 8'hFF;

  // One queued job: a burst of cnt_m1 + 1 results.
  typedef struct packed {
    logic                 nconfig;
    logic                 pulse;
    status_e              status;
    logic [BITS_PER_BYTE-1:0] bits;
    logic [BitIdxW-1:0]   cnt_m1;
  } cmd_t;

endpackage
`default_nettype wire

/* design/fpsl_front.sv */
`default_nettype none
module fpsl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 nstatus_level_i,
  input  logic                 conf_done_level_i,
  output logic                 push_o,
  output fpsl_pkg::cmd_t       push_cmd_o,
  input  logic                 full_i
);
  import fpsl_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WAIT = 5'b00010,
    PH_LOAD = 5'b00100,
    PH_DONE = 5'b01000,
    PH_FAIL = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] poll_q, poll_d, poll_inc;
  logic       ncfg_q, ncfg_d;
  logic [7:0] poll_limit_q;
  logic [2:0] extra_q;
  logic       accept;
  cmd_t       cmd;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign poll_inc   = (poll_q == PollCountMax) ? poll_q : poll_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    poll_d     = poll_q;
    ncfg_d     = ncfg_q;
    cmd.pulse  = 1'b0;
    cmd.status = ST_IGNORED;
    cmd.bits   = '0;
    cmd.cnt_m1 = '0;
    unique case (kind_e'(kind_i))
      KIND_START: begin
        if (phase_q == PH_IDLE || phase_q == PH_DONE || phase_q == PH_FAIL) begin
          ncfg_d     = 1'b1;
          poll_d     = '0;
          phase_d    = PH_WAIT;
          cmd.status = ST_WAITING;
        end
      end
      KIND_POLL: begin
        if (phase_q == PH_WAIT) begin
          if (nstatus_level_i) begin
            phase_d    = PH_LOAD;
            cmd.status = ST_READY;
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= poll_limit_q) begin
              phase_d    = PH_FAIL;
              cmd.status = ST_TIMEOUT;
            end else begin
              cmd.status = ST_WAITING;
            end
          end
        end
      end
      KIND_DATA: begin
        if (phase_q == PH_LOAD) begin
          cmd.pulse  = 1'b1;
          cmd.status = ST_READY;
          cmd.bits   = data_byte_i;
          cmd.cnt_m1 = BitIdxW'(BITS_PER_BYTE - 1);
        end
      end
      KIND_FINISH: begin
        if (phase_q == PH_LOAD) begin
          phase_d = PH_FAIL;
          if (!nstatus_level_i) begin
            cmd.status = ST_NSTATUS_FAIL;
          end else if (!conf_done_level_i) begin
            cmd.status = ST_CONFDONE_FAIL;
          end else begin
            phase_d    = PH_DONE;
            cmd.status = ST_LOADED;
            if (extra_q != 3'd0) begin
              cmd.pulse  = 1'b1;
              cmd.cnt_m1 = BitIdxW'(extra_q - 3'd1);
            end
          end
        end
      end
      default: ;
    endcase
    cmd.nconfig = ncfg_d;
  end

  assign push_o     = accept;
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      poll_q       <= '0;
      ncfg_q       <= 1'b0;
      poll_limit_q <= PollLimitReset;
      extra_q      <= ExtraClocksReset;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        poll_q  <= poll_d;
        ncfg_q  <= ncfg_d;
      end
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_POLL_LIMIT:   poll_limit_q <= cfg_data_i;
          REG_EXTRA_CLOCKS: extra_q      <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* design/fpsl_queue.sv */
`default_nettype none
module fpsl_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpsl_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output fpsl_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import fpsl_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/fpsl_back.sv */
`default_nettype none
module fpsl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fpsl_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           nconfig_level_o,
  output logic           data_bit_o,
  output logic           dclk_pulse_o,
  output logic [2:0]     status_o,
  output logic           last_o
);
  import fpsl_pkg::*;

  logic [BitIdxW-1:0] idx_q;
  logic               vld_q;
  logic               load, fin;
  logic               ncfg_q, bit_q, pulse_q, last_q;
  status_e            st_q;

  assign load  = !vld_q || !out_stall_i;
  assign fin   = (idx_q == head_i.cnt_m1);
  assign pop_o = load && valid_i && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      vld_q <= valid_i;
      if (valid_i) begin
        idx_q <= fin ? '0 : idx_q + BitIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      ncfg_q  <= head_i.nconfig;
      bit_q   <= head_i.bits[idx_q];
      pulse_q <= head_i.pulse;
      st_q    <= head_i.status;
      last_q  <= fin;
    end
  end

  assign out_valid_o     = vld_q;
  assign nconfig_level_o = ncfg_q;
  assign data_bit_o      = bit_q;
  assign dclk_pulse_o    = pulse_q;
  assign status_o        = st_q;
  assign last_o          = last_q;

endmodule
`default_nettype wire

/* design/fpga_passive_serial_loader.sv */
`default_nettype none
// Passive serial configuration master. Items (start, poll, data byte, finish) are
// taken one per cycle while the command queue has room; the front end tracks the
// phase, poll count and nCONFIG and queues one job per item. The output side plays
// each job out at one result per cycle while out_stall_i is low: a data byte gives one
// result and one DCLK pulse per bit, LSB first; a good finish gives extra_clocks
// pulsed results (one unpulsed result if zero), and every other item one result.
// Sustained throughput is set by that single output port. The queue holds QUEUE_DEPTH
// jobs, counting the one being played out. Configuration writes (index 0 poll_limit, 1
// extra_clocks) take effect at once and belong only where no item is in flight.
module fpga_passive_serial_loader #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       nstatus_level_i,
  input  logic       conf_done_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       nconfig_level_o,
  output logic       data_bit_o,
  output logic       dclk_pulse_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import fpsl_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t push_cmd, head;

  fpsl_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .data_byte_i       (data_byte_i),
    .nstatus_level_i   (nstatus_level_i),
    .conf_done_level_i (conf_done_level_i),
    .push_o            (push),
    .push_cmd_o        (push_cmd),
    .full_i            (full)
  );

  fpsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .valid_o    (q_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  fpsl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .nconfig_level_o (nconfig_level_o),
    .data_bit_o      (data_bit_o),
    .dclk_pulse_o    (dclk_pulse_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

/* sim/tb_fpga_passive_serial_loader.sv */
`timescale 1ns / 100ps

module tb_fpga_passive_serial_loader;
  import fpsl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_LOAD,
    PH_DONE,
    PH_FAIL
  } phase_e;

  typedef struct packed {
    logic    nconfig;
    logic    data_bit;
    logic    dclk;
    status_e status;
    logic    last;
  } pin_result_t;

  // cfg_en: write pl/ec first; typed: status given here, not by the predictor
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_v;
    logic       nst;
    logic       cd;
    logic       typed;
    status_e    status;
    logic       cfg_en;
    logic [7:0] pl;
    logic [2:0] ec;
  } load_step_t;

  localparam load_step_t LoadSteps [27] = '{
    '{KIND_POLL,   8'h00, 1'b0, 1'b0, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'hFF, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b1, ST_WAITING,       1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'h3C, 1'b0, 1'b0, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b0, 1'b1, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b1, 1'b0, 1'b1, ST_READY,         1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'hFF, 1'b0, 1'b0, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'h00, 1'b1, 1'b1, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'hA5, 1'b0, 1'b1, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b0, 1'b1, 1'b1, ST_NSTATUS_FAIL,  1'b0, 8'd0, 3'd0},
    '{KIND_DATA,   8'h5A, 1'b1, 1'b1, 1'b1, ST_IGNORED,       1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b1, 1'b1, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b1, 1'b0, 1'b1, ST_CONFDONE_FAIL, 1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b1, 1'b0, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b1, 1'b1, 1'b1, ST_LOADED,        1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b0, ST_IDLE,          1'b1, 8'd1, 3'd0},
    '{KIND_POLL,   8'h00, 1'b0, 1'b0, 1'b1, ST_TIMEOUT,       1'b0, 8'd0, 3'd0},
    '{KIND_START,  8'h00, 1'b0, 1'b0, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_POLL,   8'h00, 1'b1, 1'b1, 1'b0, ST_IDLE,          1'b0, 8'd0, 3'd0},
    '{KIND_FINISH, 8'h00, 1'b1, 1'b1, 1'b1, ST_LOADED,        1'b0, 8'd0, 3'd0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_idx = REG_POLL_LIMIT;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = KIND_START;
  logic [7:0] data_byte = 8'd0;
  logic       nstatus_lvl = 1'b0;
  logic       conf_done_lvl = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       nconfig_lvl;
  logic       data_bit;
  logic       dclk_pulse;
  logic [2:0] status;
  logic       last;

  fpga_passive_serial_loader u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (kind),
    .data_byte_i       (data_byte),
    .nstatus_level_i   (nstatus_lvl),
    .conf_done_level_i (conf_done_lvl),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .nconfig_level_o   (nconfig_lvl),
    .data_bit_o        (data_bit),
    .dclk_pulse_o      (dclk_pulse),
    .status_o          (status),
    .last_o            (last)
  );

  always #1 clk = ~clk;

  // loader model state
  phase_e     ph = PH_IDLE;
  logic [7:0] fail_polls = 8'd0;
  logic       nconfig_q = 1'b0;
  logic [7:0] cur_limit = PollLimitReset;
  logic [2:0] cur_extra = ExtraClocksReset;
  bit         ovr_en = 1'b0;
  status_e    ovr_status = ST_IDLE;

  pin_result_t pin_q[$];

  int  err_cnt = 0;
  int  n_items = 0;
  int  n_useful = 0;
  int  n_results = 0;
  int  n_settings = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  function automatic void push_pin(logic b, logic pulse, status_e s, logic lst);
    pin_q.push_back('{nconfig_q, b, pulse, ovr_en ? ovr_status : s, lst});
  endfunction

  // returns 1 when the item is dropped as out of phase
  function automatic bit loader_step(kind_e k, logic [7:0] b, logic ns, logic cd);
    bit ign;
    ign = 1'b0;
    case (k)
      KIND_START: begin
        if (ph == PH_WAIT || ph == PH_LOAD) begin
          ign = 1'b1;
        end else begin
          nconfig_q = 1'b1;
          fail_polls = 8'd0;
          ph = PH_WAIT;
          push_pin(1'b0, 1'b0, ST_WAITING, 1'b1);
        end
      end
      KIND_POLL: begin
        if (ph != PH_WAIT) begin
          ign = 1'b1;
        end else if (ns) begin
          ph = PH_LOAD;
          push_pin(1'b0, 1'b0, ST_READY, 1'b1);
        end else begin
          if (fail_polls != PollCountMax) fail_polls = fail_polls + 8'd1;
          if (fail_polls >= cur_limit) begin
            ph = PH_FAIL;
            push_pin(1'b0, 1'b0, ST_TIMEOUT, 1'b1);
          end else begin
            push_pin(1'b0, 1'b0, ST_WAITING, 1'b1);
          end
        end
      end
      KIND_DATA: begin
        if (ph != PH_LOAD) begin
          ign = 1'b1;
        end else begin
          for (int i = 0; i < BITS_PER_BYTE; i++)
            push_pin(b[i], 1'b1, ST_READY, i == BITS_PER_BYTE - 1);
        end
      end
      default: begin
        if (ph != PH_LOAD) begin
          ign = 1'b1;
        end else if (!ns) begin
          ph = PH_FAIL;
          push_pin(1'b0, 1'b0, ST_NSTATUS_FAIL, 1'b1);
        end else if (!cd) begin
          ph = PH_FAIL;
          push_pin(1'b0, 1'b0, ST_CONFDONE_FAIL, 1'b1);
        end else begin
          ph = PH_DONE;
          if (cur_extra == 3'd0) begin
            push_pin(1'b0, 1'b0, ST_LOADED, 1'b1);
          end else begin
            for (int i = 0; i < int'(cur_extra); i++)
              push_pin(1'b0, 1'b1, ST_LOADED, i == int'(cur_extra) - 1);
          end
        end
      end
    endcase
    if (ign) push_pin(1'b0, 1'b0, ST_IGNORED, 1'b1);
    return ign;
  endfunction

  task automatic send(kind_e k, logic [7:0] b, logic ns, logic cd, bit typed, status_e ts);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    data_byte = b;
    nstatus_lvl = ns;
    conf_done_lvl = cd;
    do @(posedge clk); while (in_stall);
    ovr_en = typed;
    ovr_status = ts;
    if (!loader_step(k, b, ns, cd)) n_useful++;
    n_items++;
  endtask

  task automatic send_noise();
    send(kind_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom),
         1'b0, ST_IDLE);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] pl, logic [2:0] ec);
    logic [4:0] pad;
    pad = 5'($urandom);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = REG_POLL_LIMIT;
    cfg_data = pl;
    @(negedge clk);
    cfg_idx = REG_EXTRA_CLOCKS;
    cfg_data = {pad, ec};
    @(negedge clk);
    cfg_we = 1'b0;
    cur_limit = pl;
    cur_extra = ec;
    n_settings++;
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pin_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pin_q.size() == 0) begin
        $error("result with no item pending");
        err_cnt++;
      end else begin
        exp_r = pin_q.pop_front();
        cmp_field("nconfig_level", exp_r.nconfig, nconfig_lvl);
        cmp_field("data_bit", exp_r.data_bit, data_bit);
        cmp_field("dclk_pulse", exp_r.dclk, dclk_pulse);
        cmp_field("status", exp_r.status, status);
        cmp_field("last", exp_r.last, last);
        n_results++;
      end
    end
  end

  initial begin
    int p;
    int fails;
    int r;
    p = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (LoadSteps[i]) begin
      if (LoadSteps[i].cfg_en) write_regs(LoadSteps[i].pl, LoadSteps[i].ec);
      send(LoadSteps[i].kind, LoadSteps[i].byte_v, LoadSteps[i].nst, LoadSteps[i].cd,
           LoadSteps[i].typed, LoadSteps[i].status);
    end

    while (n_items < 100) begin
      case (p % 4)
        0: write_regs(8'd0, 3'd7);
        1: write_regs(8'd255, 3'd0);
        2: write_regs(8'd1, 3'($urandom));
        default: write_regs(8'($urandom_range(2, 6)), 3'($urandom));
      endcase
      p++;
      repeat ($urandom_range(2, 4)) begin
        if (n_items >= 85) quiet = 1'b1;
        if ($urandom_range(0, 7) == 0) send_noise();
        send(KIND_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, ST_IDLE);
        if (cur_limit <= 8'd8) fails = $urandom_range(0, int'(cur_limit) + 1);
        else fails = $urandom_range(0, 3);
        for (int j = 0; j < fails && ph == PH_WAIT; j++)
          send(KIND_POLL, 8'($urandom), 1'b0, 1'($urandom), 1'b0, ST_IDLE);
        if (ph == PH_WAIT)
          send(KIND_POLL, 8'($urandom), 1'b1, 1'($urandom), 1'b0, ST_IDLE);
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send(KIND_DATA, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, ST_IDLE);
        end
        r = $urandom_range(0, 5);
        send(KIND_FINISH, 8'($urandom), r != 0, r != 1, 1'b0, ST_IDLE);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d in phase), checked %0d results", n_items, n_useful,
             n_results);
    $display("Register settings written after reset: %0d", n_settings);
    if (err_cnt == 0 && pin_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout with %0d results outstanding", pin_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
